>>> rtl/core/ttww_pkg.sv
// ----------------------------------------------------------------------------
// ttww_pkg
// shared types and constants of the word-wrapping text terminal
// ----------------------------------------------------------------------------
package ttww_pkg;

    localparam int LINE_WIDTH_DEF = 64;
    localparam int LINE_COUNT_DEF = 32;

    localparam int CHAR_W     = 8;
    localparam int PX_W       = 16;
    localparam int RL_W       = 5;
    localparam int RC_W       = 6;
    localparam int CNT_W      = 16;
    localparam int SCR_W      = 24;
    localparam int LH_W       = 7;
    localparam int LPS_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_SCREEN = 2'd1;

    typedef enum logic [1:0] {
        CMD_WRITE, CMD_CLEAR, CMD_SCROLL, CMD_READ
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NULL, OP_NEWLINE, OP_CHAR, OP_CLEAR, OP_SCROLL, OP_READ
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [CHAR_W-1:0]       ch;
        logic signed [PX_W-1:0]  px;
        logic [RL_W-1:0]         rl;
        logic [RC_W-1:0]         rc;
    } t_item;

    typedef struct packed {
        logic [LH_W-1:0]  row_pitch;
        logic [LPS_W-1:0] lines_per_screen;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_SCROLL, S_READ, S_SRCH_RD, S_SRCH_CHK,
        S_COPY_RD, S_COPY_WR, S_FINISH, S_TRIM, S_EMIT
    } t_state;

endpackage

>>> rtl/core/ttww_ram.sv
// ----------------------------------------------------------------------------
// ttww_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ttww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ttww_fifo.sv
// ----------------------------------------------------------------------------
// ttww_fifo
// two-entry word queue
// ----------------------------------------------------------------------------
module ttww_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/core/ttww_front.sv
// ----------------------------------------------------------------------------
// ttww_front
// accepts commands, classifies them and queues them for the executor
// ----------------------------------------------------------------------------
module ttww_front import ttww_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_command,
    input  logic [CHAR_W-1:0]      i_char_code,
    input  logic signed [PX_W-1:0] i_scroll_pixels,
    input  logic [RL_W-1:0]        i_read_line,
    input  logic [RC_W-1:0]        i_read_col,
    input  logic                   i_pop,
    output t_item                  o_item,
    output logic                   o_empty
);

    t_item                 item;
    logic [$bits(t_item)-1:0] q_data;

    always_comb begin
        item.ch = i_char_code;
        item.px = i_scroll_pixels;
        item.rl = i_read_line;
        item.rc = i_read_col;
        unique case (t_cmd'(i_command))
            CMD_WRITE: begin
                if (i_char_code == CH_NUL) begin
                    item.op = OP_NULL;
                end else if (i_char_code == CH_NL) begin
                    item.op = OP_NEWLINE;
                end else begin
                    item.op = OP_CHAR;
                end
            end
            CMD_CLEAR:  item.op = OP_CLEAR;
            CMD_SCROLL: item.op = OP_SCROLL;
            CMD_READ:   item.op = OP_READ;
            default:    item.op = OP_NULL;
        endcase
    end

    ttww_fifo #(.WIDTH($bits(t_item))) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_data  (q_data),
        .o_empty (o_empty)
    );

    assign o_item = t_item'(q_data);

endmodule

>>> rtl/core/ttww_back.sv
// ----------------------------------------------------------------------------
// ttww_back
// executes queued commands against the line ring, including wrap search/copy
// ----------------------------------------------------------------------------
module ttww_back import ttww_pkg::*; #(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF,
    parameter int LINE_COUNT = LINE_COUNT_DEF,
    localparam int CW = $clog2(LINE_WIDTH + 1),
    localparam int LW = $clog2(LINE_COUNT),
    localparam int AW = $clog2(LINE_COUNT * LINE_WIDTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_item                   i_item,
    input  logic                    i_item_empty,
    output logic                    o_item_pop,
    output logic                    o_res_push,
    input  logic                    i_res_full,
    output logic [CHAR_W-1:0]       o_read_char,
    output logic [CW-1:0]           o_read_length,
    output logic [LW-1:0]           o_line_now,
    output logic [CW-1:0]           o_column_now,
    output logic [CNT_W-1:0]        o_lines_advanced,
    output logic signed [SCR_W-1:0] o_scroll_offset
);

    t_state r_state, n_state;
    logic [LW-1:0]           r_line, n_line, r_prev, n_prev, line_inc;
    logic [CW-1:0]           r_col, n_col, r_k, n_k, r_j, n_j, r_n, n_n;
    logic [CNT_W-1:0]        r_cnt, n_cnt, cnt_inc;
    logic signed [SCR_W-1:0] r_scroll, n_scroll;
    logic [LINE_COUNT-1:0]   r_valid, n_valid;
    logic [CHAR_W-1:0]       r_ch, n_ch, r_rchar, n_rchar;
    logic [CW-1:0]           r_rlen, n_rlen;
    logic                    r_trim, n_trim, r_rd_l_ok, n_rd_l_ok, r_rd_c_ok, n_rd_c_ok;
    logic signed [SCR_W:0]   r_sum, n_sum, lim, clamp;
    logic [22:0]             r_prod, n_prod;
    logic                    rd_l_ok;

    logic              t_we;
    logic [AW-1:0]     t_waddr, t_raddr;
    logic [CHAR_W-1:0] t_wdata, t_rdata;
    logic              l_we;
    logic [LW-1:0]     l_waddr, l_raddr;
    logic [CW-1:0]     l_wdata, l_rdata;

    function automatic logic [AW-1:0] taddr(input logic [LW-1:0] line,
                                            input logic [CW-1:0] col);
        taddr = AW'(line) * AW'(LINE_WIDTH) + AW'(col);
    endfunction

    ttww_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_COUNT * LINE_WIDTH)) u_text (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    ttww_ram #(.WIDTH(CW), .DEPTH(LINE_COUNT)) u_len (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    assign line_inc = (r_line == LW'(LINE_COUNT - 1)) ? '0 : r_line + 1'b1;
    assign cnt_inc  = (&r_cnt) ? r_cnt : r_cnt + 1'b1;
    assign rd_l_ok  = 32'(i_item.rl) < LINE_COUNT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_line   <= '0;
            r_col    <= '0;
            r_cnt    <= '0;
            r_scroll <= '0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_line   <= n_line;
            r_col    <= n_col;
            r_cnt    <= n_cnt;
            r_scroll <= n_scroll;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev    <= n_prev;
        r_k       <= n_k;
        r_j       <= n_j;
        r_n       <= n_n;
        r_ch      <= n_ch;
        r_trim    <= n_trim;
        r_sum     <= n_sum;
        r_prod    <= n_prod;
        r_rd_l_ok <= n_rd_l_ok;
        r_rd_c_ok <= n_rd_c_ok;
        r_rchar   <= n_rchar;
        r_rlen    <= n_rlen;
    end

    always_comb begin
        n_state = r_state;   n_line = r_line;   n_col = r_col;
        n_cnt = r_cnt;       n_scroll = r_scroll; n_valid = r_valid;
        n_prev = r_prev;     n_k = r_k;         n_j = r_j;   n_n = r_n;
        n_ch = r_ch;         n_trim = r_trim;   n_sum = r_sum; n_prod = r_prod;
        n_rd_l_ok = r_rd_l_ok; n_rd_c_ok = r_rd_c_ok;
        n_rchar = r_rchar;   n_rlen = r_rlen;
        t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
        l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        lim   = -$signed({2'b00, r_prod});
        clamp = (r_sum > 0) ? '0 : r_sum;
        if (clamp < lim) begin
            clamp = lim;
        end
        unique case (r_state)
            S_IDLE: begin
                if (!i_item_empty) begin
                    o_item_pop = 1'b1;
                    n_rchar = '0;
                    n_rlen  = '0;
                    n_state = S_EMIT;
                    unique case (i_item.op)
                        OP_NEWLINE: begin
                            l_we = 1'b1; l_waddr = r_line; l_wdata = r_col;
                            n_valid[r_line]   = 1'b1;
                            n_valid[line_inc] = 1'b0;
                            n_line = line_inc;
                            n_col  = '0;
                            n_cnt  = cnt_inc;
                        end
                        OP_CHAR: begin
                            if (r_col < CW'(LINE_WIDTH)) begin
                                t_we = 1'b1;
                                t_waddr = taddr(r_line, r_col);
                                t_wdata = i_item.ch;
                                l_we = 1'b1; l_waddr = r_line; l_wdata = r_col + 1'b1;
                                n_valid[r_line] = 1'b1;
                                n_col = r_col + 1'b1;
                            end else begin
                                // line full: advance, then look back for a space unless the new character is one
                                l_we = 1'b1; l_waddr = r_line; l_wdata = r_col;
                                n_valid[r_line] = 1'b1;
                                n_prev = r_line;
                                n_line = line_inc;
                                n_col  = '0;
                                n_cnt  = cnt_inc;
                                n_ch   = i_item.ch;
                                n_k    = CW'(LINE_WIDTH);
                                n_j    = CW'(LINE_WIDTH);
                                n_n    = '0;
                                if (i_item.ch == CH_SPACE) begin
                                    n_trim  = 1'b1;
                                    n_state = S_COPY_RD;
                                end else begin
                                    n_trim  = 1'b0;
                                    n_state = S_SRCH_RD;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_valid = '0; n_line = '0; n_col = '0;
                            n_cnt = '0;   n_scroll = '0;
                        end
                        OP_SCROLL: begin
                            n_sum  = (SCR_W+1)'(r_scroll) + (SCR_W+1)'(i_item.px);
                            n_prod = (r_cnt > CNT_W'(i_cfg.lines_per_screen))
                                ? 23'(r_cnt - CNT_W'(i_cfg.lines_per_screen))
                                  * 23'(i_cfg.row_pitch)
                                : '0;
                            n_state = S_SCROLL;
                        end
                        OP_READ: begin
                            l_raddr   = LW'(i_item.rl);
                            t_raddr   = taddr(LW'(i_item.rl), CW'(i_item.rc));
                            n_rd_l_ok = rd_l_ok && r_valid[LW'(i_item.rl)];
                            n_rd_c_ok = rd_l_ok && (32'(i_item.rc) < LINE_WIDTH);
                            n_state   = S_READ;
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_SCROLL: begin
                n_scroll = clamp[SCR_W-1:0];
                n_state  = S_EMIT;
            end
            S_READ: begin
                n_rchar = r_rd_c_ok ? t_rdata : '0;
                n_rlen  = r_rd_l_ok ? l_rdata : '0;
                n_state = S_EMIT;
            end
            S_SRCH_RD: begin
                if (r_k == '0) begin
                    // no usable space: hard break
                    n_trim  = 1'b0;
                    n_j     = CW'(LINE_WIDTH);
                    n_n     = '0;
                    n_state = S_COPY_RD;
                end else begin
                    t_raddr = taddr(r_prev, r_k - 1'b1);
                    n_k     = r_k - 1'b1;
                    n_state = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                if (t_rdata == CH_SPACE && r_k != '0) begin
                    n_trim  = 1'b1;
                    n_j     = r_k;
                    n_n     = '0;
                    n_state = S_COPY_RD;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_COPY_RD: begin
                if (r_j == CW'(LINE_WIDTH)) begin
                    n_state = S_FINISH;
                end else begin
                    t_raddr = taddr(r_prev, r_j);
                    n_state = S_COPY_WR;
                end
            end
            S_COPY_WR: begin
                t_we = 1'b1;
                t_waddr = taddr(r_line, r_n);
                t_wdata = t_rdata;
                n_j = r_j + 1'b1;
                n_n = r_n + 1'b1;
                n_state = S_COPY_RD;
            end
            S_FINISH: begin
                t_we = 1'b1;
                t_waddr = taddr(r_line, r_n);
                t_wdata = r_ch;
                l_we = 1'b1; l_waddr = r_line; l_wdata = r_n + 1'b1;
                n_valid[r_line] = 1'b1;
                n_col   = r_n + 1'b1;
                n_state = r_trim ? S_TRIM : S_EMIT;
            end
            S_TRIM: begin
                l_we = 1'b1; l_waddr = r_prev; l_wdata = r_k;
                n_valid[r_prev] = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_read_char      = r_rchar;
    assign o_read_length    = r_rlen;
    assign o_line_now       = r_line;
    assign o_column_now     = r_col;
    assign o_lines_advanced = r_cnt;
    assign o_scroll_offset  = r_scroll;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(LINE_WIDTH))
        else $error("write column beyond line width");

    a_scroll_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scroll[SCR_W-1] || r_scroll == '0)
        else $error("scroll offset positive");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop && i_item.op == OP_CLEAR
        |=> r_line == '0 && r_cnt == '0 && r_scroll == '0 && r_valid == '0)
        else $error("clear did not reset position");

    a_wrap_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SRCH_CHK || r_state == S_COPY_WR |-> r_prev != r_line)
        else $error("wrap source and target line coincide");

endmodule

>>> rtl/core/text_terminal_word_wrap_core.sv
// ----------------------------------------------------------------------------
// text_terminal_word_wrap_core
// ring of text lines with word wrap, clear, scroll and character read-back
// ----------------------------------------------------------------------------
// Commands enter through a two-word queue (push/full) and each produces one
// result word on the output queue (empty/pop). Commands execute one at a
// time; scroll and read pass through one extra state before the result is
// emitted. A character arriving at a full line wraps: the text memory has
// one read port, so the backward space search alternates a read and a
// check state per column, and the tail copy a read and a write state.
// Line lengths use per-line valid bits, so clear and reset act at once;
// text memory is never cleared, and reading a never-written cell is
// undefined.
module text_terminal_word_wrap_core import ttww_pkg::*; #(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF,
    parameter int LINE_COUNT = LINE_COUNT_DEF,
    localparam int CW = $clog2(LINE_WIDTH + 1),
    localparam int LW = $clog2(LINE_COUNT)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // command side
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_command,
    input  logic [CHAR_W-1:0]       i_char_code,
    input  logic signed [PX_W-1:0]  i_scroll_pixels,
    input  logic [RL_W-1:0]         i_read_line,
    input  logic [RC_W-1:0]         i_read_col,
    // result side
    output logic                    empty,
    input  logic                    pop,
    output logic [CHAR_W-1:0]       o_read_char,
    output logic [CW-1:0]           o_read_length,
    output logic [LW-1:0]           o_line_now,
    output logic [CW-1:0]           o_column_now,
    output logic [CNT_W-1:0]        o_lines_advanced,
    output logic signed [SCR_W-1:0] o_scroll_offset
);

    localparam int RES_W = CHAR_W + CW + LW + CW + CNT_W + SCR_W;

    t_cfg  r_cfg;
    t_item item;
    logic  item_empty, item_pop, res_push, res_full;
    logic [CHAR_W-1:0]       b_char;
    logic [CW-1:0]           b_len, b_col;
    logic [LW-1:0]           b_line;
    logic [CNT_W-1:0]        b_cnt;
    logic signed [SCR_W-1:0] b_scroll;
    logic [RES_W-1:0]        res_in, res_out;

    // configuration registers, writes outside the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_pitch        <= LH_W'(16);
            r_cfg.lines_per_screen <= LPS_W'(15);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINE_HEIGHT:      r_cfg.row_pitch        <= i_cfg_data[LH_W-1:0];
                REG_LINES_PER_SCREEN: r_cfg.lines_per_screen <= i_cfg_data[LPS_W-1:0];
                default: ;
            endcase
        end
    end

    // front: accept and classify
    ttww_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_command       (i_command),
        .i_char_code     (i_char_code),
        .i_scroll_pixels (i_scroll_pixels),
        .i_read_line     (i_read_line),
        .i_read_col      (i_read_col),
        .i_pop           (item_pop),
        .o_item          (item),
        .o_empty         (item_empty)
    );

    // back: sequencer over the line ring
    ttww_back #(.LINE_WIDTH(LINE_WIDTH), .LINE_COUNT(LINE_COUNT)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_item           (item),
        .i_item_empty     (item_empty),
        .o_item_pop       (item_pop),
        .o_res_push       (res_push),
        .i_res_full       (res_full),
        .o_read_char      (b_char),
        .o_read_length    (b_len),
        .o_line_now       (b_line),
        .o_column_now     (b_col),
        .o_lines_advanced (b_cnt),
        .o_scroll_offset  (b_scroll)
    );

    // result queue decouples the sequencer from the consumer
    assign res_in = {b_char, b_len, b_line, b_col, b_cnt, b_scroll};

    ttww_fifo #(.WIDTH(RES_W)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign {o_read_char, o_read_length, o_line_now, o_column_now,
            o_lines_advanced, o_scroll_offset} = res_out;

endmodule

>>> sim/tb_text_terminal_word_wrap_core.sv
// ----------------------------------------------------------------------------
// tb_text_terminal_word_wrap_core
// self-checking bench for the word-wrapping text terminal core
// ----------------------------------------------------------------------------
// Commands go in through the push/full queue and every accepted word is run
// through an in-bench model of the terminal. Each popped result word is
// compared field by field with the oldest expected word. The run goes
// through four line-height / lines-per-screen settings, written while the
// core is idle. Most traffic is text with words and spaces, so lines fill
// and wrap. Reads target only cells that were written at some point.
// ----------------------------------------------------------------------------
module tb_text_terminal_word_wrap_core;
    import ttww_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH     = 64;
    localparam int LINES     = 32;
    localparam int IDLE_MAX  = 6000;   // cycles with no handshake at all
    localparam int DRAIN_GAP = 300;    // settle gap after a drain, longer than the longest wrap

    // ------------------------------------------------------------------------
    // terminal model and expected-word store
    // ------------------------------------------------------------------------
    class wrap_scoreboard;
        typedef struct {
            bit [7:0]  rchar;
            bit [6:0]  rlen;
            bit [4:0]  line;
            bit [6:0]  col;
            bit [15:0] adv;
            bit [23:0] scr;
        } t_term_word;

        byte unsigned text[LINES][WIDTH];
        bit           written[LINES][WIDTH];
        int           nwritten;
        int           len[LINES];
        int           line, col, adv, scroll, lh, lps;
        t_term_word   expected_words[$];
        int           errors;

        function new();
            foreach (len[i]) len[i] = 0;
            foreach (written[i, j]) written[i][j] = 0;
            nwritten = 0;
            line = 0; col = 0; adv = 0; scroll = 0;
            lh = 16; lps = 15; errors = 0;
        endfunction

        function void set_cfg(bit [1:0] idx, bit [6:0] val);
            if (idx == REG_LINE_HEIGHT) lh = val;
            else if (idx == REG_LINES_PER_SCREEN) lps = val & 7'h3f;
        endfunction

        function void put(int l, int c, byte unsigned ch);
            text[l][c] = ch;
            if (!written[l][c]) nwritten++;
            written[l][c] = 1;
        endfunction

        function void advance();
            len[line] = col;
            line = (line + 1) % LINES;
            col = 0;
            if (adv < 65535) adv++;
        endfunction

        function void write_char(byte unsigned c);
            int prev, l, k, n;
            byte unsigned ch;
            if (c == CH_NUL) return;
            if (c == CH_NL) begin
                advance();
            end else if (col >= WIDTH) begin
                // full line: wrap back to the last space of the previous line
                advance();
                prev = (line + LINES - 1) % LINES;
                l = (len[prev] > WIDTH) ? WIDTH : len[prev];
                k = l;
                ch = c;
                while (ch != CH_SPACE && k > 0) begin
                    k--;
                    ch = text[prev][k];
                end
                if (ch == CH_SPACE && k > 0) begin
                    n = l - k;
                    for (int i = 0; i < n; i++) put(line, i, text[prev][k + i]);
                    put(line, n, c);
                    col = n + 1;
                    len[prev] = k;
                end else begin
                    put(line, 0, c);
                    col = 1;
                end
            end else begin
                put(line, col, c);
                col++;
            end
            len[line] = col;
        endfunction

        function void note_word(t_cmd cmd, byte unsigned ch, shortint px,
                                int rl, int rc);
            t_term_word w;
            int lim;
            w.rchar = 0;
            w.rlen = 0;
            case (cmd)
                CMD_WRITE: write_char(ch);
                CMD_CLEAR: begin
                    foreach (len[i]) len[i] = 0;
                    line = 0; col = 0; adv = 0; scroll = 0;
                end
                CMD_SCROLL: begin
                    scroll += int'(px);
                    if (scroll > 0) scroll = 0;
                    lim = (adv > lps) ? -((adv - lps) * lh) : 0;
                    if (scroll < lim) scroll = lim;
                end
                default: begin
                    w.rchar = text[rl][rc];
                    w.rlen = len[rl];
                end
            endcase
            w.line = line;
            w.col = col;
            w.adv = adv;
            w.scr = scroll[23:0];
            expected_words.push_back(w);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(bit [7:0] rchar, bit [6:0] rlen, bit [4:0] ln,
                        bit [6:0] cl, bit [15:0] ad, bit [23:0] sc);
            t_term_word w;
            if (expected_words.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            w = expected_words.pop_front();
            if (rchar !== w.rchar) report($sformatf("read_char %0h exp %0h", rchar, w.rchar));
            if (rlen !== w.rlen) report($sformatf("read_length %0d exp %0d", rlen, w.rlen));
            if (ln !== w.line) report($sformatf("line_now %0d exp %0d", ln, w.line));
            if (cl !== w.col) report($sformatf("column_now %0d exp %0d", cl, w.col));
            if (ad !== w.adv) report($sformatf("lines_advanced %0d exp %0d", ad, w.adv));
            if (sc !== w.scr) report($sformatf("scroll_offset %0h exp %0h", sc, w.scr));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, ports
    // ------------------------------------------------------------------------
    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [1:0]        i_cfg_index = '0;
    logic [6:0]        i_cfg_data = '0;
    logic              push = 0;
    logic              full;
    logic [1:0]        i_command = '0;
    logic [7:0]        i_char_code = '0;
    logic signed [15:0] i_scroll_pixels = '0;
    logic [4:0]        i_read_line = '0;
    logic [5:0]        i_read_col = '0;
    logic              empty;
    logic              pop = 0;
    logic [7:0]        o_read_char;
    logic [6:0]        o_read_length;
    logic [4:0]        o_line_now;
    logic [6:0]        o_column_now;
    logic [15:0]       o_lines_advanced;
    logic signed [23:0] o_scroll_offset;

    always #5 i_clk = ~i_clk;

    text_terminal_word_wrap_core dut (.*);

    wrap_scoreboard sb = new();
    bit quiet = 0;      // no idling in the closing stretch
    int stall_cycles = 0;
    bit no_space_run = 0;

    // ------------------------------------------------------------------------
    // result side: pop with random stall bursts, check every popped word
    // ------------------------------------------------------------------------
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 19) == 0) begin
                pop <= 0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            pop <= 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                sb.check_word(o_read_char, o_read_length, o_line_now, o_column_now,
                              o_lines_advanced, o_scroll_offset);
            // watchdog: nothing moving on either side for too long
            if ((push && !full) || (pop && !empty)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= IDLE_MAX) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------
    task automatic send(t_cmd cmd, byte unsigned ch, shortint px, int rl, int rc);
        if (!quiet && $urandom_range(0, 15) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        push <= 1;
        i_command <= cmd;
        i_char_code <= ch;
        i_scroll_pixels <= px;
        i_read_line <= rl;
        i_read_col <= rc;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_word(cmd, ch, px, rl, rc);
    endtask

    // read of a cell that holds something; a write when nothing is stored yet
    task automatic send_read();
        int rl, rc;
        bit hit;
        hit = 0;
        if (sb.nwritten == 0) begin
            send(CMD_WRITE, 8'h41, 0, 0, 0);
            return;
        end
        for (int t = 0; t < 20 && !hit; t++) begin
            rl = $urandom_range(0, LINES - 1);
            rc = $urandom_range(0, WIDTH - 1);
            hit = sb.written[rl][rc];
        end
        for (int i = 0; i < LINES * WIDTH && !hit; i++) begin
            rl = i / WIDTH;
            rc = i % WIDTH;
            hit = sb.written[rl][rc];
        end
        send(CMD_READ, $urandom, $urandom, rl, rc);
    endtask

    // a one-cycle write strobe, then the enable goes low again
    task automatic write_cfg(bit [1:0] idx, bit [6:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
        sb.set_cfg(idx, val);
    endtask

    // hold off until every result is back, then let any wrap settle
    task automatic drain();
        push <= 0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // mostly words separated by spaces, some long unbroken runs, a few others
    task automatic random_item();
        int r;
        byte unsigned c;
        r = $urandom_range(0, 999);
        if ($urandom_range(0, 59) == 0) no_space_run = ~no_space_run;
        if (r < 760) begin
            if (!no_space_run && $urandom_range(0, 5) == 0) c = CH_SPACE;
            else if ($urandom_range(0, 9) == 0) c = $urandom_range(128, 255);
            else c = $urandom_range(33, 126);
            send(CMD_WRITE, c, $urandom, $urandom, $urandom);
        end else if (r < 790) begin
            // bursts of newlines push the advance count past a screen
            repeat ($urandom_range(1, 12)) send(CMD_WRITE, CH_NL, $urandom, $urandom, $urandom);
        end else if (r < 800) begin
            send(CMD_WRITE, $urandom_range(0, 11), $urandom, $urandom, $urandom);
        end else if (r < 880) begin
            if ($urandom_range(0, 1)) send(CMD_SCROLL, $urandom, $urandom, $urandom, $urandom);
            else send(CMD_SCROLL, $urandom, $urandom_range(0, 400) - 200, $urandom, $urandom);
        end else if (r < 995) begin
            send_read();
        end else begin
            send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        bit [6:0] lh_set[4]  = '{7'd1, 7'd64, 7'd7, 7'd33};
        bit [6:0] lps_set[4] = '{7'd1, 7'd32, 7'd5, 7'd30};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed opening: corner characters, null, newline, scroll extremes
        write_cfg(REG_LINE_HEIGHT, lh_set[0]);
        write_cfg(REG_LINES_PER_SCREEN, lps_set[0]);
        send(CMD_WRITE, 8'h41, 0, 0, 0);
        send(CMD_WRITE, CH_NUL, 0, 0, 0);
        send(CMD_WRITE, 8'hff, 0, 0, 0);
        send(CMD_WRITE, CH_SPACE, 0, 0, 0);
        send(CMD_WRITE, 8'h80, 0, 0, 0);
        send(CMD_READ, 0, 0, 0, 0);
        send(CMD_READ, 0, 0, 0, 2);
        send(CMD_WRITE, CH_NL, 0, 0, 0);
        send(CMD_WRITE, CH_NL, 0, 0, 0);
        send(CMD_WRITE, CH_NL, 0, 0, 0);
        send(CMD_SCROLL, 0, 16'sh7fff, 0, 0);
        send(CMD_SCROLL, 0, -16'sh8000, 0, 0);
        send(CMD_SCROLL, 0, -16'sd1, 0, 0);
        send(CMD_READ, 0, 0, 0, 1);
        send(CMD_CLEAR, 0, 0, 0, 0);
        send(CMD_SCROLL, 0, -16'sd5, 0, 0);
        send(CMD_READ, 0, 0, 0, 0);

        // random phases, one register setting each; last phase without gaps
        for (int p = 0; p < 4; p++) begin
            if (p > 0) begin
                drain();
                write_cfg(REG_LINE_HEIGHT, lh_set[p]);
                write_cfg(REG_LINES_PER_SCREEN, lps_set[p]);
            end
            quiet = (p == 3);
            repeat (200) random_item();
        end

        push <= 0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/ttww_pkg.sv
rtl/core/ttww_ram.sv
rtl/core/ttww_fifo.sv
rtl/core/ttww_front.sv
rtl/core/ttww_back.sv
rtl/core/text_terminal_word_wrap_core.sv
sim/tb_text_terminal_word_wrap_core.sv
